@@ rtl/core/ebf_pkg.sv @@
`timescale 1ns / 1ps

package ebf_pkg;

    localparam int NUM_SOURCES_DEF = 32;
    localparam int NUM_SLOTS_DEF   = 8;
    localparam int COUNT_MAX_DEF   = 65535;

    localparam int CODE_W  = 16;
    localparam int MASK_W  = 16;
    localparam int COUNT_W = 16;
    localparam int TYPE_W  = 4;

    localparam logic [2:0] OP_CHECK   = 3'd0;
    localparam logic [2:0] OP_ENABLE  = 3'd1;
    localparam logic [2:0] OP_DISABLE = 3'd2;
    localparam logic [2:0] OP_LOAD    = 3'd3;
    localparam logic [2:0] OP_ACTIVE  = 3'd4;

    localparam logic [2:0] KIND_DEBUG    = 3'd1;
    localparam logic [2:0] KIND_INFO     = 3'd2;
    localparam logic [2:0] KIND_ERROR    = 3'd3;
    localparam logic [2:0] KIND_CRITICAL = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic [4:0]         source_index;
        logic [CODE_W-1:0]  event_code;
        logic [2:0]         event_kind;
        logic [TYPE_W-1:0]  type_bits;
        logic [2:0]         slot_number;
        logic [MASK_W-1:0]  slot_mask;
        logic               slot_used;
        logic               active_value;
    } cmd_t;

    typedef struct packed {
        logic dropped;
        logic lock_reached;
        logic slot_hit;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [CODE_W-1:0]  code;
        logic [MASK_W-1:0]  mask;
        logic [COUNT_W-1:0] count;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

@@ rtl/core/ebf_ram.sv @@
`timescale 1ns / 1ps

module ebf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/ebf_row_update.sv @@
`timescale 1ns / 1ps

module ebf_row_update #(
    parameter int NUM_SOURCES = ebf_pkg::NUM_SOURCES_DEF,
    parameter int NUM_SLOTS   = ebf_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_MAX   = ebf_pkg::COUNT_MAX_DEF
) (
    input  ebf_pkg::cmd_t                        cmd,
    input  logic                                 active,
    input  logic [ebf_pkg::TYPE_W-1:0]           enables,
    input  ebf_pkg::slot_t [NUM_SLOTS-1:0]       slots,
    output logic                                 active_new,
    output logic [ebf_pkg::TYPE_W-1:0]           enables_new,
    output ebf_pkg::slot_t [NUM_SLOTS-1:0]       slots_new,
    output logic                                 write_en,
    output ebf_pkg::rsp_t                        rsp
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [ebf_pkg::COUNT_W-1:0] CNT_MAX = ebf_pkg::COUNT_W'(COUNT_MAX);

    logic                       src_ok;
    logic                       kind_en;
    logic                       hit;
    logic [SW-1:0]              hit_idx;
    ebf_pkg::slot_t             sel;
    logic [ebf_pkg::COUNT_W-1:0] cnt_inc;

    assign src_ok = 32'(cmd.source_index) < NUM_SOURCES;

    always_comb
    begin
        unique case (cmd.event_kind)
            ebf_pkg::KIND_DEBUG:    kind_en = enables[0];
            ebf_pkg::KIND_INFO:     kind_en = enables[1];
            ebf_pkg::KIND_ERROR:    kind_en = enables[2];
            ebf_pkg::KIND_CRITICAL: kind_en = enables[3];
            default:                kind_en = 1'b0;
        endcase
    end

    // first valid slot holding the code wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (slots[i].valid && slots[i].code == cmd.event_code)
            begin
                hit     = 1'b1;
                hit_idx = SW'(i);
            end
        end
    end

    assign sel     = slots[hit_idx];
    assign cnt_inc = sel.count + 1'b1;

    always_comb
    begin
        active_new  = active;
        enables_new = enables;
        slots_new   = slots;
        write_en    = 1'b0;
        rsp         = '0;
        unique case (cmd.operation)
            ebf_pkg::OP_CHECK:
            begin
                if (!src_ok || !active || !kind_en)
                begin
                    rsp.dropped = 1'b1;
                end
                else if (hit)
                begin
                    write_en     = 1'b1;
                    rsp.slot_hit = 1'b1;
                    rsp.dropped  = |(sel.mask & sel.count);
                    if (sel.count < CNT_MAX)
                    begin
                        slots_new[hit_idx].count = cnt_inc;
                        rsp.lock_reached         = (cnt_inc == CNT_MAX);
                    end
                end
            end
            ebf_pkg::OP_ENABLE:
            begin
                write_en    = src_ok;
                enables_new = enables | cmd.type_bits;
            end
            ebf_pkg::OP_DISABLE:
            begin
                write_en    = src_ok;
                enables_new = enables & ~cmd.type_bits;
            end
            ebf_pkg::OP_LOAD:
            begin
                if (32'(cmd.slot_number) < NUM_SLOTS)
                begin
                    write_en = src_ok;
                    slots_new[SW'(cmd.slot_number)].valid = cmd.slot_used;
                    slots_new[SW'(cmd.slot_number)].code  = cmd.event_code;
                    slots_new[SW'(cmd.slot_number)].mask  = cmd.slot_mask;
                    slots_new[SW'(cmd.slot_number)].count = '0;
                end
            end
            ebf_pkg::OP_ACTIVE:
            begin
                write_en   = src_ok;
                active_new = cmd.active_value;
            end
            default:
            begin
                write_en = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/event_binary_filter.sv @@
`timescale 1ns / 1ps

// Per-source event filter.
// Command channel (cmd_valid / cmd_stall / cmd) carries one word per
// operation: check, enable types, disable types, load slot, set active.
// Response channel (rsp_valid / rsp_stall / rsp) returns exactly one word
// per command, in order: dropped, lock_reached, slot_hit (all zero for
// non-check operations).
// Each source's state (active flag, type enables, all filter slots) is one
// row of a single-port-read synchronous RAM. A command reads its row in the
// accept cycle and writes the modified row back when it advances, in the
// same cycle that the response is loaded into the output register.
// A new command is not accepted while the previous one waits on its row.
// While the response register is full and stalled, a command waiting on its
// row holds; the command side stalls until it moves on.
// Reset clears per-row valid flops at once; an unwritten row reads as zero,
// so no clearing pass is needed.
module event_binary_filter #(
    parameter int NUM_SOURCES = ebf_pkg::NUM_SOURCES_DEF,
    parameter int NUM_SLOTS   = ebf_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_MAX   = ebf_pkg::COUNT_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  ebf_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ebf_pkg::rsp_t rsp
);

    localparam int AW     = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SLOTS_W = NUM_SLOTS * ebf_pkg::SLOT_W;
    localparam int ROW_W  = 1 + ebf_pkg::TYPE_W + SLOTS_W;

    logic                    s1_valid_reg, s1_valid_next;
    ebf_pkg::cmd_t           s1_cmd_reg;
    logic                    s1_row_ok_reg;
    logic [NUM_SOURCES-1:0]  row_ok_reg;
    logic                    rsp_valid_reg, rsp_valid_next;
    ebf_pkg::rsp_t           rsp_reg;

    logic                    accept;
    logic                    advance;
    logic                    src_ok_in;
    logic [AW-1:0]           cmd_addr;
    logic [AW-1:0]           s1_addr;
    logic [ROW_W-1:0]        rd_row;
    logic [ROW_W-1:0]        cur_row;
    logic [ROW_W-1:0]        wr_row;

    logic                               cur_active, new_active;
    logic [ebf_pkg::TYPE_W-1:0]         cur_enables, new_enables;
    ebf_pkg::slot_t [NUM_SLOTS-1:0]     cur_slots, new_slots;
    logic                               upd_wr;
    ebf_pkg::rsp_t                      upd_rsp;

    assign cmd_stall = s1_valid_reg;
    assign accept    = cmd_valid && !cmd_stall;
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign src_ok_in = 32'(cmd.source_index) < NUM_SOURCES;
    assign cmd_addr  = AW'(cmd.source_index);
    assign s1_addr   = AW'(s1_cmd_reg.source_index);

    ebf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SOURCES),
        .AW    (AW)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (advance && upd_wr),
        .wr_addr (s1_addr),
        .wr_data (wr_row),
        .rd_en   (accept),
        .rd_addr (cmd_addr),
        .rd_data (rd_row)
    );

    assign cur_row     = s1_row_ok_reg ? rd_row : '0;
    assign cur_active  = cur_row[ROW_W-1];
    assign cur_enables = cur_row[SLOTS_W +: ebf_pkg::TYPE_W];
    assign cur_slots   = cur_row[SLOTS_W-1:0];
    assign wr_row      = {new_active, new_enables, new_slots};

    ebf_row_update #(
        .NUM_SOURCES (NUM_SOURCES),
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_MAX   (COUNT_MAX)
    ) u_update (
        .cmd         (s1_cmd_reg),
        .active      (cur_active),
        .enables     (cur_enables),
        .slots       (cur_slots),
        .active_new  (new_active),
        .enables_new (new_enables),
        .slots_new   (new_slots),
        .write_en    (upd_wr),
        .rsp         (upd_rsp)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            s1_row_ok_reg <= 1'b0;
            row_ok_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                s1_row_ok_reg <= src_ok_in && row_ok_reg[cmd_addr];
            end
            if (advance && upd_wr)
            begin
                row_ok_reg[s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
        end
        if (advance)
        begin
            rsp_reg <= upd_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
